// File: hw/rtl/tlk_pkg.sv
// shared types and codes for the top-k lowest score keeper
`timescale 1ns / 1ps

package tlk_pkg;

    // number of cells built into the row
    localparam int CAPACITY = 16;

    // operation codes of an input transaction
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // shift mode broadcast to every cell of the row
    typedef struct packed {
        logic open_insert;   // store not full: shift toward higher slots
        logic evict_insert;  // store full: drop slot 0, shift toward lower slots
    } cell_ctl_t;

endpackage

// File: hw/rtl/top_k_lowest_score_keeper.sv
// top level: command port, fill count and the row of sorted cells
`timescale 1ns / 1ps

// Keeps the entries with the lowest scores, sorted worst (slot 0) to best.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. operation selects insert (new_score, new_tag) or read
// (read_slot). Every transaction gives one result on accepted, entry_valid,
// entry_score, entry_tag and fill_count, shown for one cycle with done high.
// The result is registered and appears in the cycle after the transaction is taken.
// Throughput: one transaction per cycle; busy stays low, since every cell
// compares against the new score in parallel and trades with its neighbor
// in the same cycle the transaction is taken.
// The result is held only for its done cycle; the receiver cannot stall.
// Configuration: cfg_write loads cfg_data into the kept-entry limit; 0 acts
// as 1 and values above CAPACITY act as CAPACITY. Write it while idle.
// Reset clears the fill count and sets the limit to 16; stored entries are
// not cleared, and slots at or past the fill count read as empty.

module top_k_lowest_score_keeper
    import tlk_pkg::*;
#(
    parameter int SCORE_BITS = 16,
    parameter int TAG_BITS   = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [4:0]            cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  operation,
    input  logic [SCORE_BITS-1:0] new_score,
    input  logic [TAG_BITS-1:0]   new_tag,
    input  logic [3:0]            read_slot,
    output logic                  done,
    output logic                  accepted,
    output logic                  entry_valid,
    output logic [SCORE_BITS-1:0] entry_score,
    output logic [TAG_BITS-1:0]   entry_tag,
    output logic [4:0]            fill_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [4:0]       limit_cfg_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             accepted_reg;
    logic             accepted_next;
    logic             valid_reg;
    logic             valid_next;
    logic [SCORE_BITS-1:0] out_score_reg;
    logic [SCORE_BITS-1:0] out_score_next;
    logic [TAG_BITS-1:0]   out_tag_reg;
    logic [TAG_BITS-1:0]   out_tag_next;

    logic [SCORE_BITS-1:0] cell_score [CAPACITY];
    logic [TAG_BITS-1:0]   cell_tag   [CAPACITY];
    logic [CAPACITY-1:0]   cell_ge;
    logic [CAPACITY-1:0]   cell_occ;

    logic [31:0] count_w;
    logic [31:0] limit_w;
    logic        take;
    logic        full;
    logic        do_open;
    logic        do_evict;
    cell_ctl_t   ctl;

    assign busy    = 1'b0;
    assign take    = start && !busy;
    assign count_w = 32'(count_reg);

    always_comb
    begin
        priority if (limit_cfg_reg == 5'd0)
            limit_w = 32'd1;
        else if (32'(limit_cfg_reg) > CAPACITY)
            limit_w = CAPACITY;
        else
            limit_w = 32'(limit_cfg_reg);
    end

    assign full     = count_w >= limit_w;
    assign do_open  = take && (operation == OP_INSERT) && !full;
    // when full, slot 0 is occupied; only a strictly better score evicts it
    assign do_evict = take && (operation == OP_INSERT) && full
                      && (cell_score[0] > new_score);

    assign ctl.open_insert  = do_open;
    assign ctl.evict_insert = do_evict;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [SCORE_BITS-1:0] l_score;
        logic [TAG_BITS-1:0]   l_tag;
        logic                  l_ge;
        logic [SCORE_BITS-1:0] r_score;
        logic [TAG_BITS-1:0]   r_tag;
        logic                  r_ge;

        assign cell_occ[i] = 32'(i) < count_w;

        if (i == 0)
        begin : g_first
            assign l_score = new_score;
            assign l_tag   = new_tag;
            assign l_ge    = 1'b1;
        end
        else
        begin : g_mid_left
            assign l_score = cell_score[i-1];
            assign l_tag   = cell_tag[i-1];
            assign l_ge    = cell_ge[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_score = new_score;
            assign r_tag   = new_tag;
            assign r_ge    = 1'b0;
        end
        else
        begin : g_mid_right
            assign r_score = cell_score[i+1];
            assign r_tag   = cell_tag[i+1];
            assign r_ge    = cell_ge[i+1];
        end

        tlk_cell #(
            .SCORE_BITS (SCORE_BITS),
            .TAG_BITS   (TAG_BITS)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (cell_occ[i]),
            .new_score   (new_score),
            .new_tag     (new_tag),
            .left_score  (l_score),
            .left_tag    (l_tag),
            .left_ge     (l_ge),
            .right_score (r_score),
            .right_tag   (r_tag),
            .right_ge    (r_ge),
            .score       (cell_score[i]),
            .tag         (cell_tag[i]),
            .ge          (cell_ge[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        accepted_next  = 1'b0;
        valid_next     = 1'b0;
        out_score_next = '0;
        out_tag_next   = '0;
        if (do_open)
        begin
            count_next    = count_reg + CNT_W'(1);
            accepted_next = 1'b1;
        end
        else if (do_evict)
        begin
            accepted_next  = 1'b1;
            valid_next     = 1'b1;
            out_score_next = cell_score[0];
            out_tag_next   = cell_tag[0];
        end
        else if (take && (operation == OP_READ))
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if ((32'(read_slot) == i) && cell_occ[i])
                begin
                    valid_next     = 1'b1;
                    out_score_next = cell_score[i];
                    out_tag_next   = cell_tag[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_cfg_reg <= 5'd16;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                limit_cfg_reg <= cfg_data;
            count_reg <= count_next;
            done_reg  <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            accepted_reg  <= accepted_next;
            valid_reg     <= valid_next;
            out_score_reg <= out_score_next;
            out_tag_reg   <= out_tag_next;
        end
    end

    logic [31:0] fill_w;

    assign fill_w      = 32'(count_reg);
    assign done        = done_reg;
    assign accepted    = accepted_reg;
    assign entry_valid = valid_reg;
    assign entry_score = out_score_reg;
    assign entry_tag   = out_tag_reg;
    assign fill_count  = fill_w[4:0];

endmodule

// File: hw/rtl/tlk_cell.sv
// one slot of the sorted row: holds an entry and trades it with its neighbors
`timescale 1ns / 1ps

module tlk_cell
    import tlk_pkg::*;
#(
    parameter int SCORE_BITS = 16,
    parameter int TAG_BITS   = 16
)
(
    input  logic                  clk,
    input  cell_ctl_t             ctl,
    input  logic                  occupied,
    input  logic [SCORE_BITS-1:0] new_score,
    input  logic [TAG_BITS-1:0]   new_tag,
    input  logic [SCORE_BITS-1:0] left_score,
    input  logic [TAG_BITS-1:0]   left_tag,
    input  logic                  left_ge,
    input  logic [SCORE_BITS-1:0] right_score,
    input  logic [TAG_BITS-1:0]   right_tag,
    input  logic                  right_ge,
    output logic [SCORE_BITS-1:0] score,
    output logic [TAG_BITS-1:0]   tag,
    output logic                  ge
);

    logic [SCORE_BITS-1:0] score_reg;
    logic [SCORE_BITS-1:0] score_next;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [TAG_BITS-1:0]   tag_next;

    // occupied and not better than the incoming entry
    assign ge = occupied && (score_reg >= new_score);

    always_comb
    begin
        score_next = score_reg;
        tag_next   = tag_reg;
        if (ctl.open_insert)
        begin
            // entries with score >= new stay, the first one past them takes new
            if (!ge)
            begin
                if (left_ge)
                begin
                    score_next = new_score;
                    tag_next   = new_tag;
                end
                else
                begin
                    score_next = left_score;
                    tag_next   = left_tag;
                end
            end
        end
        else if (ctl.evict_insert)
        begin
            if (right_ge)
            begin
                score_next = right_score;
                tag_next   = right_tag;
            end
            else if (ge)
            begin
                score_next = new_score;
                tag_next   = new_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        tag_reg   <= tag_next;
    end

    assign score = score_reg;
    assign tag   = tag_reg;

endmodule

// File: dv/tb_top_k_lowest_score_keeper.sv
// testbench for the top-k lowest score keeper: directed table, then random traffic
`timescale 1ns / 1ps

module tb_top_k_lowest_score_keeper
    import tlk_pkg::*;
();

    localparam int SLOTS          = 16;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic        accepted;
        logic        entry_valid;
        logic [15:0] entry_score;
        logic [15:0] entry_tag;
        logic [4:0]  fill_count;
    } keeper_result_t;

    typedef enum logic [1:0] {
        ROW_WRITE_LIMIT,
        ROW_SEND,
        ROW_SEND_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t      kind;
        logic [4:0]     limit;
        logic           op;
        logic [15:0]    score;
        logic [15:0]    tag;
        logic [3:0]     slot;
        keeper_result_t typed;
    } plan_row_t;

    localparam keeper_result_t NO_RESULT = '0;

    // typed rows carry their result; the rest go through the ranking predictor
    localparam plan_row_t DIRECTED_PLAN [26] = '{
        '{ROW_SEND_TYPED,  5'd0,  OP_READ,   16'h0000, 16'h0000, 4'd0,  NO_RESULT},
        '{ROW_SEND_TYPED,  5'd0,  OP_READ,   16'h0000, 16'h0000, 4'd15, NO_RESULT},
        // limit of zero behaves as one kept entry
        '{ROW_WRITE_LIMIT, 5'd0,  OP_INSERT, 16'h0000, 16'h0000, 4'd0,  NO_RESULT},
        '{ROW_SEND_TYPED,  5'd0,  OP_INSERT, 16'hFFFF, 16'hFFFF, 4'd0,
            '{1'b1, 1'b0, 16'h0000, 16'h0000, 5'd1}},
        '{ROW_SEND_TYPED,  5'd0,  OP_INSERT, 16'hFFFF, 16'h1234, 4'd0,
            '{1'b0, 1'b0, 16'h0000, 16'h0000, 5'd1}},
        '{ROW_SEND_TYPED,  5'd0,  OP_INSERT, 16'h0000, 16'h0000, 4'd0,
            '{1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 5'd1}},
        '{ROW_SEND_TYPED,  5'd0,  OP_READ,   16'h0000, 16'h0000, 4'd0,
            '{1'b0, 1'b1, 16'h0000, 16'h0000, 5'd1}},
        '{ROW_SEND_TYPED,  5'd0,  OP_INSERT, 16'h0000, 16'h0005, 4'd0,
            '{1'b0, 1'b0, 16'h0000, 16'h0000, 5'd1}},
        '{ROW_WRITE_LIMIT, 5'd4,  OP_INSERT, 16'h0000, 16'h0000, 4'd0,  NO_RESULT},
        // equal scores land behind the ones already kept
        '{ROW_SEND,        5'd0,  OP_INSERT, 16'd300,  16'd1,    4'd0,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_INSERT, 16'd300,  16'd2,    4'd0,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_INSERT, 16'd100,  16'd3,    4'd0,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_READ,   16'h0000, 16'h0000, 4'd0,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_READ,   16'h0000, 16'h0000, 4'd1,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_READ,   16'h0000, 16'h0000, 4'd3,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_INSERT, 16'd200,  16'd4,    4'd0,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_INSERT, 16'd300,  16'd5,    4'd0,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_INSERT, 16'd100,  16'd6,    4'd0,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_READ,   16'h0000, 16'h0000, 4'd2,  NO_RESULT},
        // limit dropped under the fill count: full, shift spans every occupied slot
        '{ROW_WRITE_LIMIT, 5'd2,  OP_INSERT, 16'h0000, 16'h0000, 4'd0,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_INSERT, 16'd50,   16'd7,    4'd0,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_INSERT, 16'h8000, 16'h7FFF, 4'd0,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_READ,   16'h0000, 16'h0000, 4'd3,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_READ,   16'h0000, 16'h0000, 4'd4,  NO_RESULT},
        '{ROW_WRITE_LIMIT, 5'd16, OP_INSERT, 16'h0000, 16'h0000, 4'd0,  NO_RESULT},
        '{ROW_SEND,        5'd0,  OP_INSERT, 16'h7FFF, 16'hAAAA, 4'd0,  NO_RESULT}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [4:0]  cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic        operation = OP_INSERT;
    logic [15:0] new_score = '0;
    logic [15:0] new_tag = '0;
    logic [3:0]  read_slot = '0;
    logic        done;
    logic        accepted;
    logic        entry_valid;
    logic [15:0] entry_score;
    logic [15:0] entry_tag;
    logic [4:0]  fill_count;

    // shadow copy of the kept entries, sorted worst first
    logic [15:0] shadow_score [SLOTS];
    logic [15:0] shadow_tag [SLOTS];
    int          shadow_count = 0;
    int          shadow_limit = 16;

    keeper_result_t pending_results [$];
    keeper_result_t typed_result = '0;
    bit             typed_armed = 1'b0;
    int             fault_count = 0;
    int             cycle_count = 0;

    top_k_lowest_score_keeper u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .new_score   (new_score),
        .new_tag     (new_tag),
        .read_slot   (read_slot),
        .done        (done),
        .accepted    (accepted),
        .entry_valid (entry_valid),
        .entry_score (entry_score),
        .entry_tag   (entry_tag),
        .fill_count  (fill_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic keeper_result_t rank_and_store(input logic op, input logic [15:0] score,
                                                      input logic [15:0] tag,
                                                      input logic [3:0] slot);
        keeper_result_t r;
        int lim;
        int pos;
        int i;
        r = '0;
        lim = (shadow_limit == 0) ? 1 : ((shadow_limit > SLOTS) ? SLOTS : shadow_limit);
        if (op == OP_READ)
        begin
            if (int'(slot) < shadow_count)
            begin
                r.entry_valid = 1'b1;
                r.entry_score = shadow_score[slot];
                r.entry_tag   = shadow_tag[slot];
            end
        end
        else if (shadow_count < lim)
        begin
            pos = 0;
            while (pos < shadow_count && shadow_score[pos] >= score)
                pos++;
            for (i = shadow_count; i > pos; i--)
            begin
                shadow_score[i] = shadow_score[i - 1];
                shadow_tag[i]   = shadow_tag[i - 1];
            end
            shadow_score[pos] = score;
            shadow_tag[pos]   = tag;
            shadow_count++;
            r.accepted = 1'b1;
        end
        else if (score < shadow_score[0])
        begin
            r.accepted    = 1'b1;
            r.entry_valid = 1'b1;
            r.entry_score = shadow_score[0];
            r.entry_tag   = shadow_tag[0];
            pos = 0;
            // worst drops out, better entries slide down until the new one fits
            while (pos + 1 < shadow_count && shadow_score[pos + 1] >= score)
            begin
                shadow_score[pos] = shadow_score[pos + 1];
                shadow_tag[pos]   = shadow_tag[pos + 1];
                pos++;
            end
            shadow_score[pos] = score;
            shadow_tag[pos]   = tag;
        end
        r.fill_count = 5'(shadow_count);
        return r;
    endfunction

    // results are checked first, so a transaction taken at this edge is queued behind them
    always @(posedge clk)
    begin : result_check
        keeper_result_t got;
        keeper_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{accepted, entry_valid, entry_score, entry_tag, fill_count};
                if (pending_results.size() == 0)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display("unexpected result: acc=%0d valid=%0d score=%h tag=%h fill=%0d",
                                 got.accepted, got.entry_valid, got.entry_score,
                                 got.entry_tag, got.fill_count);
                    fault_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.accepted !== want.accepted || got.entry_valid !== want.entry_valid
                        || got.entry_score !== want.entry_score
                        || got.entry_tag !== want.entry_tag
                        || got.fill_count !== want.fill_count)
                    begin
                        if (fault_count < REPORT_LIMIT)
                        begin
                            $display("mismatch at %0t: exp acc=%0d valid=%0d score=%h tag=%h fill=%0d",
                                     $realtime, want.accepted, want.entry_valid,
                                     want.entry_score, want.entry_tag, want.fill_count);
                            $display("    got acc=%0d valid=%0d score=%h tag=%h fill=%0d",
                                     got.accepted, got.entry_valid, got.entry_score,
                                     got.entry_tag, got.fill_count);
                        end
                        fault_count++;
                    end
                end
            end
            if (cfg_write)
                shadow_limit = int'(cfg_data);
            if (start && !busy)
            begin
                want = rank_and_store(operation, new_score, new_tag, read_slot);
                if (typed_armed)
                    want = typed_result;
                pending_results.push_back(want);
            end
        end
    end

    task automatic send_item(input logic op, input logic [15:0] score, input logic [15:0] tag,
                             input logic [3:0] slot, input bit typed,
                             input keeper_result_t typed_val);
        typed_armed  = typed;
        typed_result = typed_val;
        start     <= 1'b1;
        operation <= op;
        new_score <= score;
        new_tag   <= tag;
        read_slot <= slot;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        typed_armed = 1'b0;
    endtask

    // limit changes only once the block has drained
    task automatic write_limit(input logic [4:0] limit);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= limit;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_segment(input logic [4:0] limit, input int items, input int idle_pct);
        logic        op;
        logic [15:0] score;
        logic [15:0] worst;
        int          pick;
        int          k;
        write_limit(limit);
        for (k = 0; k < items; k++)
        begin
            // every 80 transactions a burst of 20 goes out back to back
            if ((k % 80) < 60)
            begin
                // each cycle the sender stays idle with the given chance
                while ($urandom_range(0, 99) < idle_pct)
                begin
                    start <= 1'b0;
                    @(negedge clk);
                end
            end
            op = ($urandom_range(0, 99) < 22) ? OP_READ : OP_INSERT;
            pick = $urandom_range(0, 99);
            if (pick < 30)
                score = 16'($urandom);
            else if (pick < 50)
                score = 16'($urandom_range(0, 31));
            else if (pick < 85 && shadow_count != 0)
            begin
                // aim just under the worst kept score so the full store keeps moving
                worst = shadow_score[0];
                if (worst > 16'd3 && $urandom_range(0, 3) != 0)
                    score = worst - 16'($urandom_range(1, 3));
                else
                    score = worst;
            end
            else if (pick < 92)
                score = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            else
                score = 16'($urandom) | 16'h8000;
            send_item(op, score, 16'($urandom), 4'($urandom_range(0, 15)), 1'b0, NO_RESULT);
        end
    endtask

    initial
    begin : watchdog
        while (cycle_count < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("top_k_lowest_score_keeper verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        for (r = 0; r < SLOTS; r++)
        begin
            shadow_score[r] = '0;
            shadow_tag[r]   = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < 26; r++)
        begin
            if (DIRECTED_PLAN[r].kind == ROW_WRITE_LIMIT)
                write_limit(DIRECTED_PLAN[r].limit);
            else
                send_item(DIRECTED_PLAN[r].op, DIRECTED_PLAN[r].score, DIRECTED_PLAN[r].tag,
                          DIRECTED_PLAN[r].slot, DIRECTED_PLAN[r].kind == ROW_SEND_TYPED,
                          DIRECTED_PLAN[r].typed);
        end

        run_segment(5'd6, 320, 17);
        run_segment(5'd10, 320, 17);
        run_segment(5'd13, 320, 82);
        run_segment(5'd0, 320, 82);
        run_segment(5'd31, 320, 0);
        run_segment(5'd1, 320, 0);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("top_k_lowest_score_keeper verification clean");
        else
            $display("top_k_lowest_score_keeper verification failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tlk_pkg.sv
hw/rtl/tlk_cell.sv
hw/rtl/top_k_lowest_score_keeper.sv
dv/tb_top_k_lowest_score_keeper.sv
